// ----- hw/rtl/icds_pkg.sv -----
// Package for the serial clock divider search block.
// Types, widths and constants shared by the divider cells, pick cells and top level.
// No dependencies.
package icds_pkg;

  localparam int W          = 32;                 // datapath width of the dividers
  localparam int NUM_EXP    = 8;                  // prescale exponents searched
  localparam int DIV_LIMIT  = 256;                // first rejected divider value
  localparam int DIV_W      = $clog2(DIV_LIMIT);  // divider field width
  localparam int EXP_W      = 3;                  // exponent field width
  localparam int RATE_W     = 31;                 // request and clock field width
  localparam int ACH_W      = 30;                 // achieved rate field width
  localparam logic [W-1:0] DIV_OFFSET = W'(4);
  localparam logic [RATE_W-1:0] CLK_RESET = RATE_W'(120000000);

  // one restoring division stage worth of state
  typedef struct packed {
    logic         vld;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] den;
  } lane_t;

  // one divider setting under test
  typedef struct packed {
    logic             ok;
    logic [DIV_W-1:0] div;
    logic [EXP_W-1:0] expo;
    logic [W-1:0]     got;
    logic [W-1:0]     err;
  } cand_t;

  typedef cand_t [NUM_EXP-1:0] cand_vec_t;

  // best setting so far
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [DIV_W-1:0] div;
    logic [EXP_W-1:0] expo;
    logic [W-1:0]     got;
    logic [W-1:0]     err;
  } best_t;

  // request data that travels beside the second divider row
  typedef struct packed {
    logic [RATE_W-1:0]                rate;
    logic [NUM_EXP-1:0]               ok;
    logic [NUM_EXP-1:0][DIV_W-1:0]    div;
  } side_t;

endpackage

// ----- hw/rtl/icds_div_cell.sv -----
// One quotient bit of a pipelined restoring divider.
// Depends on icds_pkg.
module icds_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          nbit,
  input  icds_pkg::lane_t lane_in,
  output icds_pkg::lane_t lane_out
);

  logic [icds_pkg::W:0]   trial;
  logic                   ge;
  logic [icds_pkg::W-1:0] rem_next;

  // shift in next numerator bit, subtract when it fits
  always_comb begin
    trial    = {lane_in.rem, nbit};
    ge       = trial >= {1'b0, lane_in.den};
    rem_next = ge ? icds_pkg::W'(trial - {1'b0, lane_in.den}) : trial[icds_pkg::W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else begin
      lane_out.vld <= lane_in.vld;
    end
    lane_out.rem <= rem_next;
    lane_out.quo <= {lane_in.quo[icds_pkg::W-2:0], ge};
    lane_out.den <= lane_in.den;
  end

endmodule

// ----- hw/rtl/icds_pick_cell.sv -----
// One compare step of the best-setting chain; consumes the head candidate.
// Depends on icds_pkg.
module icds_pick_cell (
  input  logic                clk,
  input  logic                rst,
  input  icds_pkg::best_t     best_in,
  input  icds_pkg::cand_vec_t cand_in,
  output icds_pkg::best_t     best_out,
  output icds_pkg::cand_vec_t cand_out
);

  logic take;

  // strictly smaller error wins, so earlier exponents keep ties
  assign take = cand_in[0].ok && (cand_in[0].err < best_in.err);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_out.vld <= 1'b0;
    end else begin
      best_out.vld <= best_in.vld;
    end
    if (take) begin
      best_out.found <= 1'b1;
      best_out.div   <= cand_in[0].div;
      best_out.expo  <= cand_in[0].expo;
      best_out.got   <= cand_in[0].got;
      best_out.err   <= cand_in[0].err;
    end else begin
      best_out.found <= best_in.found;
      best_out.div   <= best_in.div;
      best_out.expo  <= best_in.expo;
      best_out.got   <= best_in.got;
      best_out.err   <= best_in.err;
    end
    // move the remaining candidates up one place
    for (int j = 0; j < icds_pkg::NUM_EXP - 1; j++) begin
      cand_out[j] <= cand_in[j+1];
    end
    cand_out[icds_pkg::NUM_EXP-1] <= '0;
  end

endmodule

// ----- hw/rtl/i2c_clock_divider_search.sv -----
// Top level of the serial clock divider search.
// Depends on icds_pkg, icds_div_cell and icds_pick_cell.
//
// A request enters on any cycle with start high; busy is always low, so one
// request per clock is taken. Each result appears on the result ports for one
// cycle with done high, in request order, after passing through two rows of
// one-bit-per-cycle divider cells (2*clock/request, then 2*clock/setting for all
// exponents in parallel) and the chain of compare cells. The receiver cannot
// stall; results must be taken as they come. Write periph_clock_hz only while
// no request is in flight.
module i2c_clock_divider_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [icds_pkg::RATE_W-1:0]   target_rate_hz,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [icds_pkg::RATE_W-1:0]   cfg_data,
  output logic                          done,
  output logic                          found,
  output logic [icds_pkg::DIV_W-1:0]    period_divider,
  output logic [icds_pkg::EXP_W-1:0]    divider_exponent,
  output logic [icds_pkg::ACH_W-1:0]    achieved_rate_hz
);

  localparam int W  = icds_pkg::W;
  localparam int NE = icds_pkg::NUM_EXP;

  logic [icds_pkg::RATE_W-1:0] periph_clock_hz;
  logic [W-1:0]                clk2;

  icds_pkg::lane_t   lane_a [0:W];
  icds_pkg::lane_t   lane_b [NE][0:W];
  icds_pkg::side_t   side   [0:W];
  icds_pkg::best_t   best   [0:NE];
  icds_pkg::cand_vec_t cand [0:NE];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign clk2      = {periph_clock_hz, 1'b0};

  // clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      periph_clock_hz <= icds_pkg::CLK_RESET;
    end else if (cfg_valid) begin
      periph_clock_hz <= cfg_data;
    end
  end

  // first divider row: base quotient 2*clock / request
  always_comb begin
    lane_a[0].vld = start;
    lane_a[0].rem = '0;
    lane_a[0].quo = '0;
    lane_a[0].den = W'(target_rate_hz);
  end

  for (genvar k = 0; k < W; k++) begin : g_row_a
    icds_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .nbit     (clk2[W-1-k]),
      .lane_in  (lane_a[k]),
      .lane_out (lane_a[k+1])
    );
  end

  // form the divider setting for every exponent
  logic [W-1:0]               base;
  logic                       set_ok  [NE];
  logic [icds_pkg::DIV_W-1:0] set_div [NE];

  assign base = lane_a[W].quo - icds_pkg::DIV_OFFSET;

  for (genvar i = 0; i < NE; i++) begin : g_setting
    logic [W-1:0]               sh;
    logic [icds_pkg::DIV_W-1:0] dv;

    assign sh         = base >> i;
    assign dv         = sh[icds_pkg::DIV_W-1:0];
    assign set_ok[i]  = (lane_a[W].den != '0) && (sh < W'(icds_pkg::DIV_LIMIT));
    assign set_div[i] = dv;

    always_ff @(posedge clk) begin
      if (rst) begin
        lane_b[i][0].vld <= 1'b0;
      end else begin
        lane_b[i][0].vld <= lane_a[W].vld;
      end
      lane_b[i][0].rem <= '0;
      lane_b[i][0].quo <= '0;
      lane_b[i][0].den <= (W'(dv) << i) + icds_pkg::DIV_OFFSET;
    end
  end

  // request data for the second row
  always_ff @(posedge clk) begin
    for (int i = 0; i < NE; i++) begin
      side[0].ok[i]  <= set_ok[i];
      side[0].div[i] <= set_div[i];
    end
    side[0].rate <= lane_a[W].den[icds_pkg::RATE_W-1:0];
  end

  // second divider row: achieved rate per exponent
  for (genvar i = 0; i < NE; i++) begin : g_row_b
    for (genvar k = 0; k < W; k++) begin : g_cell
      icds_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .nbit     (clk2[W-1-k]),
        .lane_in  (lane_b[i][k]),
        .lane_out (lane_b[i][k+1])
      );
    end
  end

  // request data rides beside the second row
  for (genvar k = 0; k < W; k++) begin : g_side
    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
    end
  end

  // error of each candidate against the request
  always_ff @(posedge clk) begin
    logic [W-1:0] rq;
    logic [W-1:0] got;
    rq = W'(side[W].rate);
    if (rst) begin
      best[0].vld <= 1'b0;
    end else begin
      best[0].vld <= lane_b[0][W].vld;
    end
    best[0].found <= 1'b0;
    best[0].div   <= '0;
    best[0].expo  <= '0;
    best[0].got   <= '0;
    best[0].err   <= rq;
    for (int i = 0; i < NE; i++) begin
      got = lane_b[i][W].quo;
      cand[0][i].ok   <= side[W].ok[i];
      cand[0][i].div  <= side[W].div[i];
      cand[0][i].expo <= icds_pkg::EXP_W'(i);
      cand[0][i].got  <= got;
      cand[0][i].err  <= (rq >= got) ? (rq - got) : (got - rq);
    end
  end

  // compare chain
  for (genvar i = 0; i < NE; i++) begin : g_pick
    icds_pick_cell u_pick (
      .clk      (clk),
      .rst      (rst),
      .best_in  (best[i]),
      .cand_in  (cand[i]),
      .best_out (best[i+1]),
      .cand_out (cand[i+1])
    );
  end

  // result transaction
  assign done             = best[NE].vld;
  assign found            = best[NE].found;
  assign period_divider   = best[NE].div;
  assign divider_exponent = best[NE].expo;
  assign achieved_rate_hz = best[NE].got[icds_pkg::ACH_W-1:0];

endmodule
